// ===== sv/tea_pkg.sv =====
// Shared types, constants and the round-sum helper for the TEA cipher pipeline.
// Depends on nothing; used by tea_pipe and tea_block_cipher_unit.
`default_nettype none

package tea_pkg;

  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned STAGES    = 2 * ROUNDS;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 4'd3;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] tea_key_t;

  // One item as it travels through the pipeline
  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } tea_blk_t;

  // Running sum used in a given round; only evaluated on constants.
  // Encrypt round r uses DELTA*(r+1), decrypt round r uses DELTA*(ROUNDS-r).
  function automatic logic [WORD_W-1:0] tea_round_sum(input int unsigned rnd, input logic dec);
    logic [WORD_W-1:0] mult;
    mult = dec ? WORD_W'(ROUNDS - rnd) : WORD_W'(rnd + 1);
    return WORD_W'(DELTA * mult);
  endfunction

endpackage

`default_nettype wire

// ===== sv/tea_pipe.sv =====
// TEA round pipeline: one half-round per register stage, 2*ROUNDS stages.
// Depends on tea_pkg for widths, item type and the per-round sum constants.
`default_nettype none

module tea_pipe import tea_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_vld,
  input  wire tea_blk_t in_blk,
  input  wire tea_key_t key,
  output logic          out_vld,
  output tea_blk_t      out_blk
);

  logic     vld_r [STAGES];
  tea_blk_t blk_r [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int unsigned       RND     = s / 2;
    localparam logic              PHASE   = 1'(s % 2);
    localparam logic [WORD_W-1:0] ENC_SUM = tea_round_sum(RND, OP_ENCRYPT);
    localparam logic [WORD_W-1:0] DEC_SUM = tea_round_sum(RND, OP_DECRYPT);

    logic              vld_in;
    tea_blk_t          blk_in;
    logic              upd_left;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] tgt;
    logic [WORD_W-1:0] kl;
    logic [WORD_W-1:0] kr;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] mixv;
    logic [WORD_W-1:0] upd;
    tea_blk_t          blk_nxt;

    // Take the item from the port or from the stage before
    if (s == 0) begin : g_first
      assign vld_in = in_vld;
      assign blk_in = in_blk;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign blk_in = blk_r[s-1];
    end

    // Encrypt updates left then right; decrypt right then left
    always_comb begin
      upd_left = (PHASE == blk_in.op);
      src      = upd_left ? blk_in.right : blk_in.left;
      tgt      = upd_left ? blk_in.left  : blk_in.right;
      kl       = upd_left ? key[0] : key[2];
      kr       = upd_left ? key[1] : key[3];
      sum      = (blk_in.op == OP_DECRYPT) ? DEC_SUM : ENC_SUM;
      mixv     = ((src << 4) + kl) ^ (src + sum) ^ ((src >> 5) + kr);
      // add for encrypt, subtract for decrypt
      upd      = tgt + (mixv ^ {WORD_W{blk_in.op}}) + WORD_W'(blk_in.op);
      blk_nxt  = blk_in;
      if (upd_left) begin
        blk_nxt.left = upd;
      end else begin
        blk_nxt.right = upd;
      end
    end

    // Advance the valid bit and the item every cycle
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      blk_r[s] <= blk_nxt;
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign out_blk = blk_r[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/tea_block_cipher_unit.sv =====
// Top level of the TEA cipher: key registers, command port and result strobe.
// Depends on tea_pkg and tea_pipe.
`default_nettype none

// The unit encrypts or decrypts one 64-bit block per clock. A block is taken
// whenever start is high; busy stays low because every stage advances each
// cycle and nothing downstream can hold results back. Each block's result
// appears on out_result_left/out_result_right with out_valid high for exactly
// one cycle, after passing through one register stage per half-round, two per
// round over 32 rounds, the first loaded at the accepting edge. Results leave
// in the order the blocks came in. The four key words are written through
// the cfg_ port, which is always ready; write keys only while no block is in
// flight.

module tea_block_cipher_unit import tea_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // command channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_operation,
  input  wire logic [WORD_W-1:0]    in_block_left,
  input  wire logic [WORD_W-1:0]    in_block_right,
  // result channel
  output logic                      out_valid,
  output logic [WORD_W-1:0]         out_result_left,
  output logic [WORD_W-1:0]         out_result_right,
  // configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  tea_key_t key_r;
  tea_key_t key_nxt;
  tea_blk_t in_blk;
  tea_blk_t out_blk;
  logic     accept;

  // Pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // Decode key register writes; ignore unknown indexes
  always_comb begin
    key_nxt = key_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_WORD0: key_nxt[0] = cfg_data;
        CFG_KEY_WORD1: key_nxt[1] = cfg_data;
        CFG_KEY_WORD2: key_nxt[2] = cfg_data;
        CFG_KEY_WORD3: key_nxt[3] = cfg_data;
        default:       key_nxt    = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign in_blk.op    = in_operation;
  assign in_blk.left  = in_block_left;
  assign in_blk.right = in_block_right;

  tea_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_blk  (in_blk),
    .key     (key_r),
    .out_vld (out_valid),
    .out_blk (out_blk)
  );

  assign out_result_left  = out_blk.left;
  assign out_result_right = out_blk.right;

endmodule

`default_nettype wire
